// ===== rtl/tsp_pkg.sv =====
// Shared types, codes, tables and the request CRC for the tactile sensor poll link.
package tsp_pkg;

  localparam int unsigned BufDepth  = 26;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned CountW    = 5;
  localparam logic [7:0]  SyncByte  = 8'hFA;
  localparam logic [15:0] CrcAfterSync = 16'd831;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  DynOffset = 8'd128;
  localparam logic [CountW-1:0] LenProx = CountW'(26);
  localparam logic [CountW-1:0] LenMed  = CountW'(18);
  localparam logic [CountW-1:0] LenDist = CountW'(20);
  localparam logic [CountW-1:0] CountOver = CountW'(BufDepth + 1);
  localparam logic [CountW-1:0] DynLen  = CountW'(4);
  localparam logic [AddrW-1:0]  DynPos  = AddrW'(2);

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_RX      = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_TAXEL = 2'd1,
    KIND_DYN   = 2'd2,
    KIND_FAIL  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_PROX = 2'd0,
    CLS_MED  = 2'd1,
    CLS_DIST = 2'd2
  } cls_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         tx_byte;
    logic [3:0]         taxel_index;
    logic [15:0]        taxel_value;
    logic signed [15:0] dynamic_sample;
    logic [1:0]         sensor_class;
    logic               last;
  } tsp_res_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } tsp_mem_req_t;

  // Reflected CRC16 over the sync byte and the id; the sync byte is already folded in.
  function automatic logic [15:0] crc_for(input logic [7:0] id);
    logic [15:0] crc;
    crc = CrcAfterSync ^ {8'h00, id};
    for (int j = 0; j < 8; j++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // Buffer position of the high byte of each taxel in published order.
  function automatic logic [AddrW-1:0] taxel_pos(input logic [1:0] cls, input logic [3:0] idx);
    logic [AddrW-1:0] p;
    p = '0;
    case (cls)
      CLS_PROX: begin
        case (idx)
          4'd0: p = 5'd6;   4'd1: p = 5'd4;   4'd2: p = 5'd2;   4'd3: p = 5'd12;
          4'd4: p = 5'd10;  4'd5: p = 5'd8;   4'd6: p = 5'd18;  4'd7: p = 5'd16;
          4'd8: p = 5'd14;  4'd9: p = 5'd24;  4'd10: p = 5'd22; 4'd11: p = 5'd20;
          default: p = 5'd2;
        endcase
      end
      CLS_MED: begin
        case (idx)
          4'd0: p = 5'd4;   4'd1: p = 5'd2;   4'd2: p = 5'd8;   4'd3: p = 5'd6;
          4'd4: p = 5'd12;  4'd5: p = 5'd10;  4'd6: p = 5'd16;  4'd7: p = 5'd14;
          default: p = 5'd2;
        endcase
      end
      default: begin
        case (idx)
          4'd0: p = 5'd18;  4'd1: p = 5'd12;  4'd2: p = 5'd6;   4'd3: p = 5'd16;
          4'd4: p = 5'd10;  4'd5: p = 5'd4;   4'd6: p = 5'd14;  4'd7: p = 5'd8;
          4'd8: p = 5'd2;
          default: p = 5'd2;
        endcase
      end
    endcase
    return p;
  endfunction

  function automatic logic [3:0] taxel_last(input logic [1:0] cls);
    logic [3:0] n;
    case (cls)
      CLS_PROX: n = 4'd11;
      CLS_MED:  n = 4'd7;
      default:  n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/tactile_sensor_poll_link.sv =====
// Top level of the tactile sensor poll link: sequencer, buffer and output register.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser=opcode, tdata=sensor_id,rx_byte
//  m_axis    out  tvalid/tready          tuser=kind, tlast=last, tdata=result fields
//  cfg       in   cfg_we_i               cfg_wdata_i = data_mode
//
// A received byte or an ignored item is taken in ST_IDLE; a poll sends request bytes in
// ST_TX. A static judgement reads the header in ST_RD0, ST_RD1 and ST_CHK, then each taxel
// in ST_RDHI, ST_RDLO and ST_EMIT on the single read port of the buffer; a dynamic one likewise.
// Reset clears the control state only; the buffer is written before it is read.
// The output register lets one result wait while the sequencer moves on; a stall holds it.
module tactile_sensor_poll_link
  import tsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // sensor_id[7:0], rx_byte[15:8]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // tx_byte[7:0], taxel_index[11:8],
                                        // taxel_value[27:12], dynamic_sample[43:28],
                                        // sensor_class[45:44], zero[47:46]
  output logic [1:0]  m_axis_tuser_o,   // kind[1:0]
  output logic        m_axis_tlast_o
);

  tsp_mem_req_t mem_req;
  logic [7:0]   mem_rdata;
  logic         res_valid;
  logic         res_ready;
  tsp_res_t     res;
  logic         out_valid_q;
  tsp_res_t     out_q;

  assign res_ready = !out_valid_q || m_axis_tready_i;

  tsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[7:0]),
    .in_rx_i     (s_axis_tdata_i[15:8]),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  tsp_buf u_buf (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {2'b00, out_q.sensor_class, out_q.dynamic_sample,
                            out_q.taxel_value, out_q.taxel_index, out_q.tx_byte};

`ifndef ASSERT_OFF
  a_no_emit_while_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready_o)
    else $error("result produced while input side is open");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (mem_req.waddr < AddrW'(BufDepth)))
    else $error("buffer write beyond depth");

  a_poll_starts_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_POLL)
    |=> (!s_axis_tready_o && res_valid && res.kind == KIND_TX))
    else $error("poll did not start request bytes");

  a_taxel_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == KIND_TAXEL) |-> (res.taxel_index <= 4'd11))
    else $error("taxel index out of range");
`endif

endmodule

// ===== rtl/tsp_buf.sv =====
// Response byte buffer: one write port, one registered read port.
module tsp_buf
  import tsp_pkg::*;
(
  input  logic         clk_i,
  input  tsp_mem_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem [BufDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tsp_ctrl.sv =====
// Poll sequencer: request bytes, response capture and response judging over the buffer.
module tsp_ctrl
  import tsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   in_op_i,
  input  logic [7:0]   in_id_i,
  input  logic [7:0]   in_rx_i,
  output tsp_mem_req_t mem_req_o,
  input  logic [7:0]   mem_rdata_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output tsp_res_t     res_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TX, ST_RD0, ST_RD1, ST_CHK, ST_RDHI, ST_RDLO, ST_EMIT, ST_FAIL
  } state_e;

  typedef enum logic [1:0] {
    WAIT_IDLE   = 2'd0,
    WAIT_STATIC = 2'd1,
    WAIT_DYN    = 2'd2
  } wait_e;

  state_e            state_q, state_d;
  wait_e             wait_q, wait_d;
  logic              mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        second_q, second_d;
  logic [15:0]       crc_q, crc_d;
  logic [3:0]        idx_q, idx_d;
  logic [1:0]        cls_q, cls_d;
  logic              dyn_q, dyn_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [7:0]        hi_q, hi_d;

  logic              accept;
  logic [CountW-1:0] count_inc;
  logic [AddrW-1:0]  pos;
  logic [3:0]        last_idx;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign count_inc = count_q + CountW'(1);
  assign pos       = dyn_q ? DynPos : taxel_pos(cls_q, idx_q);
  assign last_idx  = dyn_q ? 4'd0 : taxel_last(cls_q);

  always_comb begin
    state_d  = state_q;
    wait_d   = wait_q;
    mode_d   = cfg_we_i ? cfg_wdata_i : mode_q;
    count_d  = count_q;
    second_d = second_q;
    crc_d    = crc_q;
    idx_d    = idx_q;
    cls_d    = cls_q;
    dyn_d    = dyn_q;
    hdr_ok_d = hdr_ok_q;
    hi_d     = hi_q;
    mem_req_o = '0;
    res_valid_o = 1'b0;
    res_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_POLL: begin
              count_d  = '0;
              idx_d    = '0;
              crc_d    = crc_for(in_id_i);
              second_d = mode_q ? in_id_i + DynOffset : in_id_i;
              wait_d   = mode_q ? WAIT_DYN : WAIT_STATIC;
              state_d  = ST_TX;
            end
            OP_RX: begin
              if (wait_q != WAIT_IDLE) begin
                if (count_q < CountW'(BufDepth)) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = count_q;
                  mem_req_o.wdata = in_rx_i;
                  count_d = count_inc;
                end else begin
                  count_d = CountOver;
                end
                if (wait_q == WAIT_DYN && count_d >= DynLen) begin
                  wait_d  = WAIT_IDLE;
                  dyn_d   = 1'b1;
                  idx_d   = '0;
                  state_d = ST_RD0;
                end
              end
            end
            OP_TIMEOUT: begin
              wait_d = WAIT_IDLE;
              idx_d  = '0;
              if (wait_q == WAIT_DYN) begin
                dyn_d   = 1'b1;
                state_d = (count_q >= DynLen) ? ST_RD0 : ST_FAIL;
              end else if (wait_q == WAIT_STATIC) begin
                dyn_d = 1'b0;
                if (count_q == LenProx) begin
                  cls_d   = CLS_PROX;
                  state_d = ST_RD0;
                end else if (count_q == LenMed) begin
                  cls_d   = CLS_MED;
                  state_d = ST_RD0;
                end else if (count_q == LenDist) begin
                  cls_d   = CLS_DIST;
                  state_d = ST_RD0;
                end else begin
                  state_d = ST_FAIL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TX: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_TX;
        case (idx_q[1:0])
          2'd0:    res_o.tx_byte = SyncByte;
          2'd1:    res_o.tx_byte = second_q;
          2'd2:    res_o.tx_byte = crc_q[7:0];
          default: res_o.tx_byte = crc_q[15:8];
        endcase
        res_o.last = (wait_q == WAIT_DYN) ? (idx_q == 4'd1) : (idx_q == 4'd3);
        if (res_ready_i) begin
          idx_d = idx_q + 4'd1;
          if (res_o.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD0: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = '0;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = AddrW'(1);
        hdr_ok_d = (mem_rdata_i == SyncByte);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = (hdr_ok_q && mem_rdata_i == second_q) ? ST_RDHI : ST_FAIL;
      end
      ST_RDHI: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = pos;
        state_d = ST_RDLO;
      end
      ST_RDLO: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = pos + AddrW'(1);
        hi_d = mem_rdata_i;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // The read data register holds the low byte until the next read is issued.
        res_valid_o = 1'b1;
        if (dyn_q) begin
          res_o.kind           = KIND_DYN;
          res_o.dynamic_sample = {hi_q, mem_rdata_i};
        end else begin
          res_o.kind         = KIND_TAXEL;
          res_o.taxel_index  = idx_q;
          res_o.taxel_value  = {hi_q, mem_rdata_i};
          res_o.sensor_class = cls_q;
        end
        res_o.last = (idx_q == last_idx);
        if (res_ready_i) begin
          idx_d   = idx_q + 4'd1;
          state_d = res_o.last ? ST_IDLE : ST_RDHI;
        end
      end
      ST_FAIL: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_FAIL;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wait_q   <= WAIT_IDLE;
      mode_q   <= 1'b0;
      count_q  <= '0;
      second_q <= '0;
      idx_q    <= '0;
      dyn_q    <= 1'b0;
      hdr_ok_q <= 1'b0;
      cls_q    <= CLS_PROX;
    end else begin
      state_q  <= state_d;
      wait_q   <= wait_d;
      mode_q   <= mode_d;
      count_q  <= count_d;
      second_q <= second_d;
      idx_q    <= idx_d;
      dyn_q    <= dyn_d;
      hdr_ok_q <= hdr_ok_d;
      cls_q    <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    hi_q  <= hi_d;
  end

endmodule
